// ===== hw/rtl/iir4_pkg.sv =====
// Shared types and constants for the fourth-order IIR converter filter.
// No dependencies; used by iir4_mac and iir_order4_clamped_dac_filter.
package iir4_pkg;

    // Default sample and coefficient formats
    localparam int SAMPLE_BITS_DEF    = 12;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Coefficients are 18-bit two's complement Q3.14
    localparam int COEF_BITS  = 18;
    localparam int HIST_DEPTH = 4;
    localparam int NUM_B      = HIST_DEPTH + 1;

    // Configuration channel
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 2 * COEF_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_B0_B1 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_B2_B3 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_B4    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEN_A1_A2 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEN_A3_A4 = 3'd4;

    // DAC command word: 3-bit command over 12 data bits
    localparam int                   DAC_WORD_BITS = 15;
    localparam int                   DAC_DATA_BITS = 12;
    localparam logic [DAC_WORD_BITS-1:0] DAC_CMD   = 15'h7000;

    // b0 = 1.0 after reset
    localparam logic [COEF_BITS-1:0] B0_RESET = 18'd16384;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    // Full coefficient set handed to the datapath
    typedef struct packed {
        coef_t [NUM_B-1:0]      b;
        coef_t [HIST_DEPTH-1:0] a;
    } coef_set_t;

endpackage

// ===== hw/rtl/iir4_mac.sv =====
// Single-pass direct-form I sum of products with floor and clamp.
// Depends on iir4_pkg (coefficient set type, history depth).
module iir4_mac #(
    parameter int SAMPLE_BITS    = iir4_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iir4_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]  x,
    input  logic [SAMPLE_BITS-1:0]  x_hist [iir4_pkg::HIST_DEPTH],
    input  logic [SAMPLE_BITS-1:0]  y_hist [iir4_pkg::HIST_DEPTH],
    input  iir4_pkg::coef_set_t     coefs,
    output logic [SAMPLE_BITS-1:0]  y,
    output logic                    clamped
);

    localparam int PROD_BITS = iir4_pkg::COEF_BITS + SAMPLE_BITS + 1;
    localparam int ACC_BITS  = PROD_BITS + 4;
    localparam int TOP_LSB   = COEF_FRAC_BITS + SAMPLE_BITS;

    logic signed [PROD_BITS-1:0] prod_b [iir4_pkg::NUM_B];
    logic signed [PROD_BITS-1:0] prod_a [iir4_pkg::HIST_DEPTH];
    logic signed [ACC_BITS-1:0]  acc;

    // Nine independent products, samples taken as non-negative
    always_comb
    begin
        prod_b[0] = $signed(coefs.b[0]) * $signed({1'b0, x});
        for (int k = 0; k < iir4_pkg::HIST_DEPTH; k++)
        begin
            prod_b[k+1] = $signed(coefs.b[k+1]) * $signed({1'b0, x_hist[k]});
            prod_a[k]   = $signed(coefs.a[k]) * $signed({1'b0, y_hist[k]});
        end
    end

    // Exact sum: feedforward minus feedback
    always_comb
    begin
        acc = ACC_BITS'(prod_b[0]);
        for (int k = 0; k < iir4_pkg::HIST_DEPTH; k++)
        begin
            acc = acc + ACC_BITS'(prod_b[k+1]) - ACC_BITS'(prod_a[k]);
        end
    end

    // Floor by the fraction bits, saturate to the sample range
    always_comb
    begin
        if (acc[ACC_BITS-1])
        begin
            y       = '0;
            clamped = 1'b1;
        end
        else if (|acc[ACC_BITS-2:TOP_LSB])
        begin
            y       = '1;
            clamped = 1'b1;
        end
        else
        begin
            y       = acc[TOP_LSB-1:COEF_FRAC_BITS];
            clamped = 1'b0;
        end
    end

endmodule

// ===== hw/rtl/iir_order4_clamped_dac_filter.sv =====
// An accepted sample is held in the input register; its result then moves to the result
// register, which presents it. Throughput: one sample per cycle while the output is not
// stalled; the whole filter sum and the clamp sit between the two registers, closing the
// output feedback loop. Reset (rst_n low, asynchronous): delay lines cleared, b0 = 1.0 and
// all other coefficients zero, both registers empty.
// The configuration channel is always ready. Depends on iir4_pkg and iir4_mac.
module iir_order4_clamped_dac_filter #(
    parameter int SAMPLE_BITS    = iir4_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = iir4_pkg::COEF_FRAC_BITS_DEF,
    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + iir4_pkg::DAC_WORD_BITS + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Sample input; tdata: adc_sample
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]             s_axis_tdata,

    // Result output; tdata: filtered_sample, dac_word; tuser: clamped
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0]            m_axis_tdata,
    output logic [0:0]                           m_axis_tuser,

    // Coefficient writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [iir4_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [iir4_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int CB        = iir4_pkg::COEF_BITS;
    localparam int YEXT_BITS = SAMPLE_BITS + iir4_pkg::DAC_DATA_BITS;

    iir4_pkg::coef_set_t      coefs_reg;
    logic                     in_valid_reg;
    logic [SAMPLE_BITS-1:0]   x_reg;
    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   y_reg;
    logic                     clamped_reg;
    logic [SAMPLE_BITS-1:0]   x_hist_reg [iir4_pkg::HIST_DEPTH];
    logic [SAMPLE_BITS-1:0]   y_hist_reg [iir4_pkg::HIST_DEPTH];

    logic [SAMPLE_BITS-1:0]   y_next;
    logic                     clamped_next;
    logic                     advance;
    logic [YEXT_BITS-1:0]     y_ext;
    logic [iir4_pkg::DAC_WORD_BITS-1:0] dac_word;

    // Coefficient registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // b0 = 1.0, every other coefficient zero
            coefs_reg <= '{b: {{((iir4_pkg::NUM_B - 1) * CB){1'b0}}, iir4_pkg::B0_RESET},
                           a: '0};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                iir4_pkg::REG_NUM_B0_B1:
                begin
                    coefs_reg.b[0] <= cfg_data[CB-1:0];
                    coefs_reg.b[1] <= cfg_data[2*CB-1:CB];
                end
                iir4_pkg::REG_NUM_B2_B3:
                begin
                    coefs_reg.b[2] <= cfg_data[CB-1:0];
                    coefs_reg.b[3] <= cfg_data[2*CB-1:CB];
                end
                iir4_pkg::REG_NUM_B4:
                begin
                    coefs_reg.b[4] <= cfg_data[CB-1:0];
                end
                iir4_pkg::REG_DEN_A1_A2:
                begin
                    coefs_reg.a[0] <= cfg_data[CB-1:0];
                    coefs_reg.a[1] <= cfg_data[2*CB-1:CB];
                end
                iir4_pkg::REG_DEN_A3_A4:
                begin
                    coefs_reg.a[2] <= cfg_data[CB-1:0];
                    coefs_reg.a[3] <= cfg_data[2*CB-1:CB];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline control: the held sample moves on when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            x_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Filter sum and clamp
    iir4_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .x       (x_reg),
        .x_hist  (x_hist_reg),
        .y_hist  (y_hist_reg),
        .coefs   (coefs_reg),
        .y       (y_next),
        .clamped (clamped_next)
    );

    // Delay lines, shifted oldest-first on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < iir4_pkg::HIST_DEPTH; k++)
            begin
                x_hist_reg[k] <= '0;
                y_hist_reg[k] <= '0;
            end
        end
        else if (advance)
        begin
            for (int k = iir4_pkg::HIST_DEPTH - 1; k > 0; k--)
            begin
                x_hist_reg[k] <= x_hist_reg[k-1];
                y_hist_reg[k] <= y_hist_reg[k-1];
            end
            x_hist_reg[0] <= x_reg;
            y_hist_reg[0] <= y_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y_reg       <= y_next;
            clamped_reg <= clamped_next;
        end
    end

    // Output packing
    assign y_ext    = YEXT_BITS'(y_reg);
    assign dac_word = iir4_pkg::DAC_CMD
                    | iir4_pkg::DAC_WORD_BITS'(y_ext[iir4_pkg::DAC_DATA_BITS-1:0]);

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = OUT_TDATA_BITS'({dac_word, y_reg});
    assign m_axis_tuser[0] = clamped_reg;

`ifndef SYNTHESIS
    // A saturated result sits on one of the range limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clamped_reg |-> (y_reg == '0 || y_reg == '1))
        else $error("clamped result not at a range limit");

    // The newest output history entry is the result last produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> y_hist_reg[0] == y_reg)
        else $error("output history out of step with result register");

    // A held sample is not lost or altered while the result slot is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(x_reg))
        else $error("stalled sample lost");

    // Input delay line shifts by exactly one tap per processed sample
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> x_hist_reg[1] == $past(x_hist_reg[0]) && x_hist_reg[0] == $past(x_reg))
        else $error("input delay line shift wrong");
`endif

endmodule
